[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked property that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/rchd_pkg.sv]
package rchd_pkg;

    localparam int          HASH_W       = 32;
    localparam int          ROW_W        = 8;
    localparam int          BYTE_W       = 8;
    localparam int          MAX_ROWS_DEF = 256;
    localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME    = 32'd16777619;

    // one fnv-1a byte step: xor the byte in, multiply by the prime mod 2^32
    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return HASH_W'(x * FNV_PRIME);
    endfunction

endpackage

[src/rchd_hash_mem.sv]
module rchd_hash_mem #(
    parameter int DEPTH = rchd_pkg::MAX_ROWS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [rchd_pkg::HASH_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [rchd_pkg::HASH_W-1:0] o_rdata
);
    import rchd_pkg::*;

    logic [HASH_W-1:0] r_mem [DEPTH];
    logic [HASH_W-1:0] r_rdata;

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/row_change_hash_detector_core.sv]
// row change hash detector
// input channel (i_valid / o_ready): one display cell per request, with glyph,
// color, row number and a last-in-row mark. cells of a row arrive in order.
// output channel (o_valid / i_ready): one request per finished row, with the
// row number, the 32-bit fnv-1a hash of the row's glyph and color bytes, and
// a dirty flag set when the hash differs from the one stored for that row.
// steps: a cell that does not end a row gets a glyph fold, then a color fold
// (each one constant multiply into a register). a row-end cell adds a finish
// step that compares against the previous-hash memory read (registered, issued
// on accept) and writes the new hash back; finish then loads the result into
// the output register, and waits while an earlier result is still stalled.
// reset: the running hash returns to the offset basis, then a clearing pass
// zeroes the previous-hash memory, one row a cycle, every row below MAX_ROWS, with
// o_ready low. rows at or beyond MAX_ROWS report dirty and are not stored.
// stall: a result waits in the output register; the next cells are still
// accepted, and only a second row end waits until the first result is taken.
module row_change_hash_detector_core #(
    parameter int MAX_ROWS = rchd_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rchd_pkg::BYTE_W-1:0] i_glyph,
    input  logic [rchd_pkg::BYTE_W-1:0] i_color,
    input  logic [rchd_pkg::ROW_W-1:0]  i_row,
    input  logic                        i_last_in_row,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rchd_pkg::ROW_W-1:0]  o_row_index,
    output logic [rchd_pkg::HASH_W-1:0] o_row_hash,
    output logic                        o_row_dirty
);
    import rchd_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_COLOR  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr;
    logic [HASH_W-1:0]  r_run;
    logic [HASH_W-1:0]  r_hash;
    logic [BYTE_W-1:0]  r_color;
    logic [ROW_W-1:0]   r_row;
    logic               r_last;
    logic               r_in_range;
    logic               r_out_valid;
    logic [ROW_W-1:0]   r_out_row;
    logic [HASH_W-1:0]  r_out_hash;
    logic               r_out_dirty;

    logic               accept;
    logic               out_free;
    logic               finish_fire;
    logic               clr_done;
    logic [HASH_W-1:0]  color_hash;
    logic [AW+ROW_W-1:0] in_row_ext;
    logic [AW+ROW_W-1:0] r_row_ext;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [HASH_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [HASH_W-1:0]  mem_rdata;

    // handshake and control
    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign finish_fire = (r_state == S_FINISH) && out_free;
    assign clr_done    = (r_clr_addr == AW'(MAX_ROWS - 1));
    assign color_hash  = fnv_fold(r_hash, r_color);

    // row numbers into memory addresses
    assign in_row_ext = (AW+ROW_W)'(i_row);
    assign r_row_ext  = (AW+ROW_W)'(r_row);

    // memory port: clearing pass or row-end write back
    always_comb begin
        mem_re = accept && i_last_in_row;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = finish_fire && r_in_range;
            mem_waddr = r_row_ext[AW-1:0];
            mem_wdata = r_hash;
        end
    end

    rchd_hash_mem #(
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (in_row_ext[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_COLOR;
            end
            S_COLOR: begin
                n_state = r_last ? S_FINISH : S_IDLE;
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_run       <= FNV_BASIS;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (r_state == S_COLOR && !r_last) begin
                r_run <= color_hash;
            end
            if (finish_fire) begin
                r_run <= FNV_BASIS;
            end
            if (finish_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hash     <= fnv_fold(r_run, i_glyph);
            r_color    <= i_color;
            r_row      <= i_row;
            r_last     <= i_last_in_row;
            r_in_range <= (int'(i_row) < MAX_ROWS);
        end
        if (r_state == S_COLOR) begin
            r_hash <= color_hash;
        end
        if (finish_fire) begin
            r_out_row   <= r_row;
            r_out_hash  <= r_hash;
            r_out_dirty <= !r_in_range || (r_hash != mem_rdata);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_row_index = r_out_row;
    assign o_row_hash  = r_out_hash;
    assign o_row_dirty = r_out_dirty;

endmodule

[src/rchd_checker.sv]
`include "assert_macros.svh"

module rchd_checker #(
    parameter int MAX_ROWS = rchd_pkg::MAX_ROWS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [rchd_pkg::BYTE_W-1:0] i_glyph,
    input logic [rchd_pkg::BYTE_W-1:0] i_color,
    input logic [rchd_pkg::ROW_W-1:0]  i_row,
    input logic                        i_last_in_row,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [rchd_pkg::ROW_W-1:0]  o_row_index,
    input logic [rchd_pkg::HASH_W-1:0] o_row_hash,
    input logic                        o_row_dirty
);
    import rchd_pkg::*;

    // a stalled result holds
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n,
        (o_valid && !i_ready) |=> (o_valid && $stable(o_row_index)
            && $stable(o_row_hash) && $stable(o_row_dirty)),
        "result changed while stalled")

    // one cell at a time: ready drops after each accepted request
    `ASSERT_CLKD(a_one_at_a_time, i_clk, i_rst_n,
        (i_valid && o_ready) |=> !o_ready,
        "request accepted while busy")

    // rows beyond the store always report dirty
    `ASSERT_CLKD(a_oob_dirty, i_clk, i_rst_n,
        (o_valid && (int'(o_row_index) >= MAX_ROWS)) |-> o_row_dirty,
        "out of range row not dirty")

    // reset empties the output and holds off input during clearing
    `ASSERT_ALWAYS(a_reset_quiet, i_clk,
        !i_rst_n |=> (!o_valid && !o_ready),
        "activity right after reset")

endmodule

bind row_change_hash_detector_core rchd_checker #(.MAX_ROWS(MAX_ROWS)) u_rchd_checker (.*);

[sim/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rchd_pkg::*;

    localparam int ROWS         = MAX_ROWS_DEF;
    localparam int MAX_CELLS    = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [HASH_W-1:0] hash;
        logic              dirty;
    } t_row_report;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_ready;
    logic [BYTE_W-1:0]   i_glyph       = '0;
    logic [BYTE_W-1:0]   i_color       = '0;
    logic [ROW_W-1:0]    i_row         = '0;
    logic                i_last_in_row = 1'b0;
    logic                o_valid;
    logic                i_ready       = 1'b0;
    logic [ROW_W-1:0]    o_row_index;
    logic [HASH_W-1:0]   o_row_hash;
    logic                o_row_dirty;

    // predicted row hashes and the per-row store behind the dirty flag
    logic [HASH_W-1:0]   run_hash = FNV_BASIS;
    logic [HASH_W-1:0]   stored_hash [ROWS];
    t_row_report         expected_rows [$];

    // row contents sent so far, replayed to get clean rows
    logic [BYTE_W-1:0]   saved_glyph [ROWS][MAX_CELLS];
    logic [BYTE_W-1:0]   saved_color [ROWS][MAX_CELLS];
    int                  saved_len [ROWS];

    int                  snd_idle_pct = 17;
    int                  rcv_idle_pct = 70;
    int                  cells_sent   = 0;
    int                  mismatches   = 0;
    int                  quiet_cycles = 0;

    row_change_hash_detector_core #(
        .MAX_ROWS(ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_glyph       (i_glyph),
        .i_color       (i_color),
        .i_row         (i_row),
        .i_last_in_row (i_last_in_row),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_row_index   (o_row_index),
        .o_row_hash    (o_row_hash),
        .o_row_dirty   (o_row_dirty)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // one fnv-1a byte step, product kept mod 2^32
    function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [63:0] prod;
        prod = 64'(h ^ HASH_W'(b)) * 64'(FNV_PRIME);
        return prod[HASH_W-1:0];
    endfunction

    // fold one accepted cell, queue a row report at the row end
    task automatic track_cell(input logic [BYTE_W-1:0] g, input logic [BYTE_W-1:0] c,
                              input logic [ROW_W-1:0] r, input logic last);
        logic [HASH_W-1:0] h;
        t_row_report       rep;
        h = mix_byte(mix_byte(run_hash, g), c);
        if (!last) begin
            run_hash = h;
        end else begin
            rep.row  = r;
            rep.hash = h;
            if (int'(r) < ROWS) begin
                rep.dirty      = (h != stored_hash[r]);
                stored_hash[r] = h;
            end else begin
                rep.dirty = 1'b1;
            end
            run_hash = FNV_BASIS;
            expected_rows.push_back(rep);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [HASH_W-1:0] want,
                                   input logic [HASH_W-1:0] got);
        if (mismatches < PRINT_CAP)
            $display("mismatch %s: expected %0h got %0h", what, want, got);
        mismatches++;
    endtask

    // compare one accepted row report with the oldest prediction
    task automatic check_row_report();
        t_row_report want;
        if (expected_rows.size() == 0) begin
            report_mismatch("unexpected row report, row", '0, HASH_W'(o_row_index));
        end else begin
            want = expected_rows.pop_front();
            if (o_row_index !== want.row)
                report_mismatch("row_index", HASH_W'(want.row), HASH_W'(o_row_index));
            if (o_row_hash !== want.hash)
                report_mismatch("row_hash", want.hash, o_row_hash);
            if (o_row_dirty !== want.dirty)
                report_mismatch("row_dirty", HASH_W'(want.dirty), HASH_W'(o_row_dirty));
        end
    endtask

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                check_row_report();
            if (i_valid && o_ready)
                track_cell(i_glyph, i_color, i_row, i_last_in_row);
        end
    end

    // cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("mismatch: no request accepted for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // send one cell request, with a random idle gap ahead of it
    task automatic send_cell(input logic [BYTE_W-1:0] g, input logic [BYTE_W-1:0] c,
                             input logic [ROW_W-1:0] r, input logic last);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_glyph       <= g;
        i_color       <= c;
        i_row         <= r;
        i_last_in_row <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        cells_sent++;
    endtask

    // byte extremes, single-cell rows and the highest row number
    task automatic test_byte_extremes();
        send_cell(8'h00, 8'h00, 8'd0, 1'b1);
        send_cell(8'hFF, 8'hFF, 8'd255, 1'b1);
        send_cell(8'h00, 8'hFF, 8'd1, 1'b0);
        send_cell(8'hFF, 8'h00, 8'd1, 1'b0);
        send_cell(8'hA5, 8'h5A, 8'd1, 1'b1);
    endtask

    // same content again reads clean, one changed byte reads dirty
    task automatic test_unchanged_rows();
        send_cell(8'h00, 8'h00, 8'd0, 1'b1);
        send_cell(8'hFF, 8'hFF, 8'd255, 1'b1);
        send_cell(8'h00, 8'hFF, 8'd1, 1'b0);
        send_cell(8'hFF, 8'h00, 8'd1, 1'b0);
        send_cell(8'hA5, 8'h5A, 8'd1, 1'b1);
        send_cell(8'h00, 8'hFF, 8'd1, 1'b0);
        send_cell(8'hFF, 8'h01, 8'd1, 1'b0);
        send_cell(8'hA5, 8'h5A, 8'd1, 1'b1);
    endtask

    // only the row-end cell's row number counts
    task automatic test_mid_row_change();
        send_cell(8'h41, 8'h07, 8'd7, 1'b0);
        send_cell(8'h42, 8'h0F, 8'd9, 1'b0);
        send_cell(8'h43, 8'h70, 8'd200, 1'b1);
        send_cell(8'h41, 8'h07, 8'd200, 1'b0);
        send_cell(8'h42, 8'h0F, 8'd3, 1'b0);
        send_cell(8'h43, 8'h70, 8'd200, 1'b1);
    endtask

    // an all-zero row hashes nonzero, so it is dirty once after reset
    task automatic test_all_zero_row();
        send_cell(8'h00, 8'h00, 8'd42, 1'b0);
        send_cell(8'h00, 8'h00, 8'd42, 1'b1);
        send_cell(8'h00, 8'h00, 8'd42, 1'b0);
        send_cell(8'h00, 8'h00, 8'd42, 1'b1);
    endtask

    // whole rows: replays, single-byte edits, fresh content and noisy rows
    task automatic test_random_frames(input int n_cells);
        int          stop_at;
        int          kind;
        int          len;
        int          r;
        int          k;
        logic [7:0]  row_field;
        stop_at = cells_sent + n_cells;
        while (cells_sent < stop_at) begin
            r    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ROWS - 1)
                                               : $urandom_range(0, 15);
            kind = $urandom_range(0, 9);
            if (kind <= 5 && saved_len[r] > 0) begin
                // replay, edited in one bit for some rows
                if (kind >= 4) begin
                    k = $urandom_range(0, saved_len[r] - 1);
                    if ($urandom_range(0, 1))
                        saved_glyph[r][k] ^= 8'(1 << $urandom_range(0, 7));
                    else
                        saved_color[r][k] ^= 8'(1 << $urandom_range(0, 7));
                end
            end else begin
                // fresh row, all-extreme bytes for some
                saved_len[r] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_CELLS)
                                                           : $urandom_range(1, 3);
                for (k = 0; k < saved_len[r]; k++) begin
                    if (kind == 9) begin
                        saved_glyph[r][k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        saved_color[r][k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end else begin
                        saved_glyph[r][k] = 8'($urandom_range(0, 255));
                        saved_color[r][k] = 8'($urandom_range(0, 255));
                    end
                end
            end
            len = saved_len[r];
            for (k = 0; k < len; k++) begin
                // noisy rows carry random row numbers before the row end
                row_field = (k == len - 1 || kind < 8) ? 8'(r) : 8'($urandom_range(0, 255));
                send_cell(saved_glyph[r][k], saved_color[r][k], row_field, k == len - 1);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < ROWS; i++) begin
            stored_hash[i] = '0;
            saved_len[i]   = 0;
        end

        // reset held low, then released
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver stalls heavily
        snd_idle_pct = 17;
        rcv_idle_pct = 70;
        test_byte_extremes();
        test_unchanged_rows();
        test_mid_row_change();
        test_all_zero_row();
        test_random_frames(660);

        // sender idles heavily, receiver stalls lightly
        snd_idle_pct = 70;
        rcv_idle_pct = 17;
        test_random_frames(660);

        // full rate on both sides
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_frames(680);

        // drain the outstanding row reports
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[row_change_hash_detector_core.f]
+incdir+src
src/rchd_pkg.sv
src/rchd_hash_mem.sv
src/row_change_hash_detector_core.sv
src/rchd_checker.sv
sim/tb_top.sv
